/* design/clt_pkg.sv */
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants for the configuration language tokenizer
// Item structs, lexer mode codes, token kinds and byte class helpers.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int DEF_MAX_TOKEN_COUNT = 4096;
  localparam int DEF_MAX_TEXT_BYTES  = 512;
  localparam int DEF_OFFSET_BITS     = 16;

  // result queue depth (two free entries are needed per accepted byte)
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [2:0] KIND_IDENT = 3'd0;
  localparam logic [2:0] KIND_NUM   = 3'd1;
  localparam logic [2:0] KIND_STR   = 3'd2;
  localparam logic [2:0] KIND_OP    = 3'd3;
  localparam logic [2:0] KIND_OTHER = 3'd4;

  typedef enum logic [10:0] {
    MODE_IDLE  = 11'b000_0000_0001,
    MODE_MINUS = 11'b000_0000_0010,
    MODE_SLASH = 11'b000_0000_0100,
    MODE_LINE  = 11'b000_0000_1000,
    MODE_BLOCK = 11'b000_0001_0000,
    MODE_BSTAR = 11'b000_0010_0000,
    MODE_IDENT = 11'b000_0100_0000,
    MODE_INT   = 11'b000_1000_0000,
    MODE_FRAC  = 11'b001_0000_0000,
    MODE_STR   = 11'b010_0000_0000,
    MODE_ESC   = 11'b100_0000_0000
  } mode_e;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] start_offset;
    logic [8:0]  text_length;
    logic [7:0]  first_byte;
    logic [11:0] token_index;
    logic        last_of_run;
  } out_item_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  // space, TAB, LF, VT, FF, CR
  function automatic logic is_space(logic [7:0] b);
    return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  function automatic logic is_op(logic [7:0] b);
    return (b == "=") || (b == "{") || (b == "}") || (b == "[") || (b == "]") ||
           (b == "(") || (b == ")") || (b == ".") || (b == ",") || (b == "+") ||
           (b == "-") || (b == "*") || (b == "/");
  endfunction

endpackage

/* design/clt_step.sv */
// ----------------------------------------------------------------------------
// clt_step: per-byte lexer update
// Next lexer state and up to two token results for one source byte.
// ----------------------------------------------------------------------------
module clt_step #(
  parameter int MAX_TOKEN_COUNT = clt_pkg::DEF_MAX_TOKEN_COUNT,
  parameter int MAX_TEXT_BYTES  = clt_pkg::DEF_MAX_TEXT_BYTES,
  parameter int OFFSET_BITS     = clt_pkg::DEF_OFFSET_BITS,
  parameter int CNT_W           = $clog2(MAX_TOKEN_COUNT + 1),
  parameter int LEN_W           = $clog2(MAX_TEXT_BYTES)
) (
  input  clt_pkg::in_item_t     item,
  input  clt_pkg::mode_e        mode_i,
  input  logic [OFFSET_BITS-1:0] offset_i,
  input  logic [OFFSET_BITS-1:0] start_i,
  input  logic [7:0]            first_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [LEN_W-1:0]      len_i,
  output clt_pkg::mode_e        mode_nxt,
  output logic [OFFSET_BITS-1:0] offset_nxt,
  output logic [OFFSET_BITS-1:0] start_nxt,
  output logic [7:0]            first_nxt,
  output logic [CNT_W-1:0]      count_nxt,
  output logic [LEN_W-1:0]      len_nxt,
  output clt_pkg::out_item_t    res0,
  output clt_pkg::out_item_t    res1,
  output logic [1:0]            res_n
);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TEXT_BYTES - 1);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
  localparam logic [CNT_W:0]   CNT_LIM = (CNT_W + 1)'(MAX_TOKEN_COUNT);

  typedef struct packed {
    logic                   v;
    logic [2:0]             kind;
    logic [OFFSET_BITS-1:0] start;
    logic [LEN_W-1:0]       len;
    logic [7:0]             first;
  } cand_t;

  function automatic cand_t flush_of(clt_pkg::mode_e m, logic [OFFSET_BITS-1:0] st,
                                     logic [LEN_W-1:0] ln, logic [7:0] fb);
    cand_t c;
    c.v     = 1'b1;
    c.kind  = clt_pkg::KIND_IDENT;
    c.start = st;
    c.len   = ln;
    c.first = fb;
    case (m)
      clt_pkg::MODE_IDENT: c.kind = clt_pkg::KIND_IDENT;
      clt_pkg::MODE_INT,
      clt_pkg::MODE_FRAC:  c.kind = clt_pkg::KIND_NUM;
      clt_pkg::MODE_MINUS,
      clt_pkg::MODE_SLASH: begin
        c.kind = clt_pkg::KIND_OP;
        c.len  = LEN_ONE;
      end
      clt_pkg::MODE_STR,
      clt_pkg::MODE_ESC:   c.kind = clt_pkg::KIND_STR;
      default:             c.v = 1'b0;
    endcase
    return c;
  endfunction

  function automatic logic [LEN_W-1:0] len_inc(logic [LEN_W-1:0] ln);
    return (ln == LEN_MAX) ? ln : ln + LEN_ONE;
  endfunction

  function automatic clt_pkg::out_item_t to_item(cand_t c, logic [CNT_W-1:0] idx,
                                                 logic last);
    clt_pkg::out_item_t      r;
    logic [OFFSET_BITS+15:0] w_off;
    logic [LEN_W+8:0]        w_len;
    logic [CNT_W+11:0]       w_idx;
    w_off = {16'b0, c.start};
    w_len = {9'b0, c.len};
    w_idx = {12'b0, idx};
    r.token_kind   = c.kind;
    r.start_offset = w_off[15:0];
    r.text_length  = w_len[8:0];
    r.first_byte   = c.first;
    r.token_index  = w_idx[11:0];
    r.last_of_run  = last;
    return r;
  endfunction

  logic [7:0]             b;
  logic                   ends;
  logic [OFFSET_BITS-1:0] off_inc;
  clt_pkg::mode_e         m;
  logic [OFFSET_BITS-1:0] st;
  logic [7:0]             fb;
  logic [LEN_W-1:0]       ln;
  logic                   rescan;
  cand_t                  c_flush, c_single, c_end, p0, p1;
  logic                   e0, e1;

  always_comb begin
    b       = item.source_byte;
    ends    = item.end_of_source || (b == 8'd0);
    off_inc = (offset_i == '1) ? offset_i : offset_i + OFFSET_BITS'(1);
    m       = mode_i;
    st      = start_i;
    fb      = first_i;
    ln      = len_i;
    rescan  = 1'b0;
    c_flush = '0;
    c_single = '0;
    c_end   = '0;

    if (b != 8'd0) begin
      case (mode_i)
        clt_pkg::MODE_IDENT: begin
          if (clt_pkg::is_alpha(b) || clt_pkg::is_digit(b) || (b == "_") || (b == "-")) begin
            ln = len_inc(ln);
          end else begin
            c_flush = flush_of(mode_i, start_i, len_i, first_i);
            rescan  = 1'b1;
          end
        end
        clt_pkg::MODE_INT: begin
          if (clt_pkg::is_digit(b)) begin
            ln = len_inc(ln);
          end else if (b == ".") begin
            ln = len_inc(ln);
            m  = clt_pkg::MODE_FRAC;
          end else begin
            c_flush = flush_of(mode_i, start_i, len_i, first_i);
            rescan  = 1'b1;
          end
        end
        clt_pkg::MODE_FRAC: begin
          if (clt_pkg::is_digit(b)) begin
            ln = len_inc(ln);
          end else begin
            c_flush = flush_of(mode_i, start_i, len_i, first_i);
            rescan  = 1'b1;
          end
        end
        clt_pkg::MODE_MINUS: begin
          if (clt_pkg::is_digit(b)) begin
            ln = len_inc(ln);
            m  = clt_pkg::MODE_INT;
          end else begin
            c_flush = flush_of(mode_i, start_i, len_i, first_i);
            rescan  = 1'b1;
          end
        end
        clt_pkg::MODE_SLASH: begin
          if (b == "/") begin
            m = clt_pkg::MODE_LINE;
          end else if (b == "*") begin
            m = clt_pkg::MODE_BLOCK;
          end else begin
            c_flush = flush_of(mode_i, start_i, len_i, first_i);
            rescan  = 1'b1;
          end
        end
        clt_pkg::MODE_LINE: begin
          if (b == "\n") m = clt_pkg::MODE_IDLE;
        end
        clt_pkg::MODE_BLOCK: begin
          if (b == "*") m = clt_pkg::MODE_BSTAR;
        end
        clt_pkg::MODE_BSTAR: begin
          if (b == "/") m = clt_pkg::MODE_IDLE;
          else if (b != "*") m = clt_pkg::MODE_BLOCK;
        end
        clt_pkg::MODE_STR: begin
          if (b == "\"") begin
            c_flush = flush_of(mode_i, start_i, len_i, first_i);
            m       = clt_pkg::MODE_IDLE;
          end else begin
            if (ln == '0) fb = b;
            ln = len_inc(ln);
            if (b == "\\") m = clt_pkg::MODE_ESC;
          end
        end
        clt_pkg::MODE_ESC: begin
          if (ln == '0) fb = b;
          ln = len_inc(ln);
          m  = clt_pkg::MODE_STR;
        end
        default: rescan = 1'b1;
      endcase

      // byte that ended a token (or arrived between tokens) starts the next one
      if (rescan) begin
        m = clt_pkg::MODE_IDLE;
        if (clt_pkg::is_space(b)) begin
          m = clt_pkg::MODE_IDLE;
        end else if (b == "#") begin
          m = clt_pkg::MODE_LINE;
        end else if (b == "/") begin
          st = offset_i; fb = b; ln = LEN_ONE;
          m  = clt_pkg::MODE_SLASH;
        end else if (clt_pkg::is_alpha(b) || (b == "_")) begin
          st = offset_i; fb = b; ln = LEN_ONE;
          m  = clt_pkg::MODE_IDENT;
        end else if (clt_pkg::is_digit(b)) begin
          st = offset_i; fb = b; ln = LEN_ONE;
          m  = clt_pkg::MODE_INT;
        end else if (b == "-") begin
          st = offset_i; fb = b; ln = LEN_ONE;
          m  = clt_pkg::MODE_MINUS;
        end else if (b == "\"") begin
          st = off_inc; fb = 8'd0; ln = '0;
          m  = clt_pkg::MODE_STR;
        end else begin
          c_single.v     = 1'b1;
          c_single.kind  = clt_pkg::is_op(b) ? clt_pkg::KIND_OP : clt_pkg::KIND_OTHER;
          c_single.start = offset_i;
          c_single.len   = LEN_ONE;
          c_single.first = b;
        end
      end
    end

    if (ends) c_end = flush_of(m, st, ln, fb);

    // at most two of the three candidates are ever valid
    p0 = c_flush.v ? c_flush : (c_single.v ? c_single : c_end);
    p1 = c_flush.v ? (c_single.v ? c_single : c_end) : (c_single.v ? c_end : cand_t'('0));

    e0 = p0.v && ({1'b0, count_i} < CNT_LIM);
    e1 = p1.v && e0 && (({1'b0, count_i} + (CNT_W + 1)'(1)) < CNT_LIM);

    res0  = to_item(p0, count_i, !e1);
    res1  = to_item(p1, count_i + CNT_W'(1), 1'b1);
    res_n = {1'b0, e0} + {1'b0, e1};

    if (ends) begin
      mode_nxt   = clt_pkg::MODE_IDLE;
      offset_nxt = '0;
      start_nxt  = '0;
      first_nxt  = 8'd0;
      count_nxt  = '0;
      len_nxt    = '0;
    end else begin
      mode_nxt   = m;
      offset_nxt = off_inc;
      start_nxt  = st;
      first_nxt  = fb;
      count_nxt  = count_i + CNT_W'(e0) + CNT_W'(e1);
      len_nxt    = ln;
    end
  end

endmodule

/* design/clt_outq.sv */
// ----------------------------------------------------------------------------
// clt_outq: token result queue
// Small register queue: up to two results in per cycle, one out if out_ready.
// ----------------------------------------------------------------------------
module clt_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  clt_pkg::out_item_t push0,
  input  clt_pkg::out_item_t push1,
  input  logic [1:0]         push_n,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output clt_pkg::out_item_t out_data
);

  localparam int CW = $clog2(clt_pkg::Q_DEPTH + 1);

  clt_pkg::out_item_t        q_r [clt_pkg::Q_DEPTH];
  logic [clt_pkg::Q_AW-1:0]  wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]             fill_r, fill_nxt;
  logic                      pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (fill_r != '0);
  assign out_data  = q_r[rptr_r];
  // two free entries cover the worst case of one byte
  assign room      = (fill_r <= CW'(clt_pkg::Q_DEPTH - 2));

  always_comb begin
    wptr_nxt = wptr_r + clt_pkg::Q_AW'(push_n);
    rptr_nxt = rptr_r + clt_pkg::Q_AW'(pop);
    fill_nxt = fill_r + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wptr_r] <= push0;
    if (push_n == 2'd2) q_r[wptr_r + clt_pkg::Q_AW'(1)] <= push1;
  end

endmodule

/* design/config_language_tokenizer.sv */
// ----------------------------------------------------------------------------
// config_language_tokenizer: streaming lexer for a configuration language
// A token is queued when the byte ending it is accepted; out_valid shows it.
// Throughput: one source byte per cycle while in_ready is high; a byte that
//   ends a token and emits another pushes two results into the 4-entry queue.
// in_ready drops only when the queue holds more than two results.
// Reset (rst_n low, synchronous): lexer idle, offsets and token count zero,
//   result queue empty.
// ----------------------------------------------------------------------------
module config_language_tokenizer #(
  parameter int MAX_TOKEN_COUNT = clt_pkg::DEF_MAX_TOKEN_COUNT,
  parameter int MAX_TEXT_BYTES  = clt_pkg::DEF_MAX_TEXT_BYTES,
  parameter int OFFSET_BITS     = clt_pkg::DEF_OFFSET_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  clt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output clt_pkg::out_item_t out_data
);

  localparam int CNT_W = $clog2(MAX_TOKEN_COUNT + 1);
  localparam int LEN_W = $clog2(MAX_TEXT_BYTES);

  // lexer state, updated once per accepted byte
  clt_pkg::mode_e         mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;   // offset of the next byte
  logic [OFFSET_BITS-1:0] start_r, start_nxt;     // start of the open token
  logic [7:0]             first_r, first_nxt;     // its first text byte
  logic [CNT_W-1:0]       count_r, count_nxt;     // tokens emitted so far
  logic [LEN_W-1:0]       len_r, len_nxt;         // clipped text length

  clt_pkg::out_item_t     res0, res1;
  logic [1:0]             res_n;
  logic                   accept;

  assign accept = in_valid && in_ready;

  clt_step #(
    .MAX_TOKEN_COUNT (MAX_TOKEN_COUNT),
    .MAX_TEXT_BYTES  (MAX_TEXT_BYTES),
    .OFFSET_BITS     (OFFSET_BITS),
    .CNT_W           (CNT_W),
    .LEN_W           (LEN_W)
  ) u_step (
    .item       (in_data),
    .mode_i     (mode_r),
    .offset_i   (offset_r),
    .start_i    (start_r),
    .first_i    (first_r),
    .count_i    (count_r),
    .len_i      (len_r),
    .mode_nxt   (mode_nxt),
    .offset_nxt (offset_nxt),
    .start_nxt  (start_nxt),
    .first_nxt  (first_nxt),
    .count_nxt  (count_nxt),
    .len_nxt    (len_nxt),
    .res0       (res0),
    .res1       (res1),
    .res_n      (res_n)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= clt_pkg::MODE_IDLE;
      offset_r <= '0;
      start_r  <= '0;
      first_r  <= 8'd0;
      count_r  <= '0;
      len_r    <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      offset_r <= offset_nxt;
      start_r  <= start_nxt;
      first_r  <= first_nxt;
      count_r  <= count_nxt;
      len_r    <= len_nxt;
    end
  end

  // results go straight into the queue; nothing is pushed without an accept
  clt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (res0),
    .push1     (res1),
    .push_n    (accept ? res_n : 2'd0),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // end of source (flag or zero byte) returns the lexer to its reset state
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.end_of_source || (in_data.source_byte == 8'd0)))
      |=> (mode_r == clt_pkg::MODE_IDLE) && (count_r == '0) && (offset_r == '0))
    else $error("lexer state not cleared after end of source");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, count_r} <= (CNT_W + 1)'(MAX_TOKEN_COUNT))
    else $error("token count beyond limit");

  a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result queue");

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result dropped without being taken");

endmodule

/* tb/config_language_tokenizer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_language_tokenizer_tb: self-checking bench for the streaming lexer
// Feeds source bytes over a valid/ready channel and checks every token
// descriptor against a cycle-free software lexer kept inside the bench.
// ----------------------------------------------------------------------------
module config_language_tokenizer_tb;
  import clt_pkg::*;

  // Limits of the default build, mirrored for the expected-token lexer.
  localparam int unsigned TOKEN_CAP  = DEF_MAX_TOKEN_COUNT;
  localparam int unsigned TEXT_CLIP  = DEF_MAX_TEXT_BYTES - 1;
  localparam int unsigned OFFSET_TOP = (1 << DEF_OFFSET_BITS) - 1;

  // Watchdog: cycles with no item moving on either channel.
  localparam int QUIET_LIMIT = 2000;
  // Forced receiver stall used to back the block up into in_ready low.
  localparam int LONG_HOLD   = 200;
  localparam int MAX_REPORTS = 10;

  localparam string OP_CHARS    = "={}[]().,+-*/";
  localparam string IDENT_CHARS =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-";
  localparam string ODD_CHARS   = "!$%&;:<>?@^`|~'";

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  config_language_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  in_item_t  source_q[$];      // bytes waiting to be offered to the block
  out_item_t token_q[$];       // token descriptors the block still owes us
  int        pushed_bytes = 0;
  int        send_gap_pct = 0;
  int        recv_gap_pct = 0;
  int        hold_req = 0;     // bumped by the stimulus thread
  int        hold_ack = 0;     // follows hold_req inside the receiver
  int        hold_left = 0;
  int        quiet_cycles = 0;
  int        bad_count = 0;
  logic      in_took = 1'b0;   // item accepted at the last rising edge

  // --------------------------------------------------------------------------
  // Expected-token lexer. Mirrors the block's scan state: one call per
  // accepted byte, zero to two descriptors appended to token_q.
  // --------------------------------------------------------------------------
  mode_e       lex_mode;
  int unsigned scan_pos;
  int unsigned tok_start;
  logic [7:0]  tok_first;
  int unsigned tok_count;
  int unsigned tok_len;
  out_item_t   step_tokens[$];

  function automatic bit ch_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit ch_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  // space plus TAB through CR
  function automatic bit ch_blank(logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic bit ch_punct(logic [7:0] b);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < OP_CHARS.len(); i++)
      if (OP_CHARS[i] == b) hit = 1'b1;
    return hit;
  endfunction

  function automatic int unsigned next_pos(int unsigned p);
    return (p >= OFFSET_TOP) ? OFFSET_TOP : p + 1;
  endfunction

  task automatic clear_lexer();
    lex_mode  = MODE_IDLE;
    scan_pos  = 0;
    tok_start = 0;
    tok_first = 8'h00;
    tok_count = 0;
    tok_len   = 0;
  endtask

  // Tokens past the cap vanish without using up an index.
  task automatic push_token(logic [2:0] kind, int unsigned start, int unsigned len,
                            logic [7:0] first);
    out_item_t t;
    if (tok_count >= TOKEN_CAP || step_tokens.size() >= 2) return;
    t.token_kind   = kind;
    t.start_offset = start[15:0];
    t.text_length  = 9'((len > TEXT_CLIP) ? TEXT_CLIP : len);
    t.first_byte   = first;
    t.token_index  = tok_count[11:0];
    t.last_of_run  = 1'b0;
    step_tokens.push_back(t);
    tok_count++;
  endtask

  task automatic grow_len();
    if (tok_len < TEXT_CLIP) tok_len++;
  endtask

  task automatic open_token(logic [7:0] b, int unsigned at);
    tok_start = at;
    tok_first = b;
    tok_len   = 1;
  endtask

  // Emit whatever token is in flight; comments just disappear.
  task automatic close_token();
    case (lex_mode)
      MODE_IDENT:            push_token(KIND_IDENT, tok_start, tok_len, tok_first);
      MODE_INT, MODE_FRAC:   push_token(KIND_NUM, tok_start, tok_len, tok_first);
      MODE_MINUS, MODE_SLASH: push_token(KIND_OP, tok_start, 1, tok_first);
      MODE_STR, MODE_ESC:    push_token(KIND_STR, tok_start, tok_len, tok_first);
      default: ;
    endcase
  endtask

  // Byte seen between tokens (or the byte that just ended one).
  task automatic scan_fresh(logic [7:0] b, int unsigned at);
    lex_mode = MODE_IDLE;
    if (ch_blank(b)) return;
    if (b == "#") begin
      lex_mode = MODE_LINE;
    end else if (b == "/") begin
      open_token(b, at);
      lex_mode = MODE_SLASH;
    end else if (ch_letter(b) || b == "_") begin
      open_token(b, at);
      lex_mode = MODE_IDENT;
    end else if (ch_digit(b)) begin
      open_token(b, at);
      lex_mode = MODE_INT;
    end else if (b == "-") begin
      open_token(b, at);
      lex_mode = MODE_MINUS;
    end else if (b == "\"") begin
      // string text starts after the opening quote
      tok_start = next_pos(at);
      tok_first = 8'h00;
      tok_len   = 0;
      lex_mode  = MODE_STR;
    end else begin
      push_token(ch_punct(b) ? KIND_OP : KIND_OTHER, at, 1, b);
    end
  endtask

  task automatic string_byte(logic [7:0] b);
    if (tok_len == 0) tok_first = b;
    grow_len();
  endtask

  task automatic predict_tokens(in_item_t it);
    logic [7:0]  b;
    int unsigned at;
    out_item_t   t;
    b = it.source_byte;
    step_tokens.delete();
    if (b == 8'h00) begin
      // zero byte: flush and start over, end flag is irrelevant
      close_token();
      clear_lexer();
    end else begin
      at = scan_pos;
      scan_pos = next_pos(at);
      case (lex_mode)
        MODE_IDENT: begin
          if (ch_letter(b) || ch_digit(b) || b == "_" || b == "-") grow_len();
          else begin close_token(); scan_fresh(b, at); end
        end
        MODE_INT: begin
          if (ch_digit(b)) grow_len();
          else if (b == ".") begin grow_len(); lex_mode = MODE_FRAC; end
          else begin close_token(); scan_fresh(b, at); end
        end
        MODE_FRAC: begin
          if (ch_digit(b)) grow_len();
          else begin close_token(); scan_fresh(b, at); end
        end
        MODE_MINUS: begin
          if (ch_digit(b)) begin grow_len(); lex_mode = MODE_INT; end
          else begin close_token(); scan_fresh(b, at); end
        end
        MODE_SLASH: begin
          if (b == "/") lex_mode = MODE_LINE;
          else if (b == "*") lex_mode = MODE_BLOCK;
          else begin close_token(); scan_fresh(b, at); end
        end
        MODE_LINE: begin
          if (b == 8'h0A) lex_mode = MODE_IDLE;
        end
        MODE_BLOCK: begin
          if (b == "*") lex_mode = MODE_BSTAR;
        end
        MODE_BSTAR: begin
          if (b == "/") lex_mode = MODE_IDLE;
          else if (b != "*") lex_mode = MODE_BLOCK;
        end
        MODE_STR: begin
          if (b == "\"") begin
            close_token();
            lex_mode = MODE_IDLE;
          end else begin
            string_byte(b);
            if (b == "\\") lex_mode = MODE_ESC;
          end
        end
        MODE_ESC: begin
          // escaped byte is text whatever it is
          string_byte(b);
          lex_mode = MODE_STR;
        end
        default: scan_fresh(b, at);
      endcase
      if (it.end_of_source) begin
        close_token();
        clear_lexer();
      end
    end
    foreach (step_tokens[i]) begin
      t = step_tokens[i];
      t.last_of_run = (i == step_tokens.size() - 1);
      token_q.push_back(t);
    end
  endtask

  // --------------------------------------------------------------------------
  // Source text generation
  // --------------------------------------------------------------------------
  task automatic put_byte(logic [7:0] b, bit last = 1'b0);
    in_item_t it;
    it.source_byte   = b;
    it.end_of_source = last;
    source_q.push_back(it);
    pushed_bytes++;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  function automatic logic [7:0] blank_byte();
    int r;
    r = $urandom_range(5);
    return (r == 0) ? 8'h20 : 8'(8 + r);
  endfunction

  // Any nonzero byte other than the one given.
  function automatic logic [7:0] byte_but(logic [7:0] skip);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == skip);
    return b;
  endfunction

  // String body byte that neither closes nor escapes.
  function automatic logic [7:0] plain_str_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == "\"" || b == "\\");
    return b;
  endfunction

  task automatic put_random_token();
    int r;
    int k;
    r = $urandom_range(16);
    if (r <= 3) begin
      put_byte($urandom_range(5) == 0 ? "_" : pick(IDENT_CHARS.substr(0, 51)));
      k = $urandom_range(7);
      repeat (k) put_byte(pick(IDENT_CHARS));
    end else if (r <= 6) begin
      if ($urandom_range(2) == 0) put_byte("-");
      k = $urandom_range(1, 5);
      repeat (k) put_byte(pick("0123456789"));
      if ($urandom_range(2) == 0) begin
        put_byte(".");
        k = $urandom_range(3);
        repeat (k) put_byte(pick("0123456789"));
      end
    end else if (r <= 8) begin
      put_byte("\"");
      k = $urandom_range(8);
      repeat (k) begin
        if ($urandom_range(6) == 0) begin
          put_byte("\\");
          put_byte(8'($urandom_range(1, 255)));
        end else begin
          put_byte(plain_str_byte());
        end
      end
      if ($urandom_range(6) != 0) put_byte("\"");
    end else if (r <= 11) begin
      put_byte(pick(OP_CHARS));
    end else if (r == 12) begin
      k = $urandom_range(1, 3);
      repeat (k) put_byte(blank_byte());
    end else if (r == 13) begin
      if ($urandom_range(1)) put_byte("#");
      else put_text("//");
      k = $urandom_range(6);
      repeat (k) put_byte(byte_but(8'h0A));
      if ($urandom_range(4) != 0) put_byte(8'h0A);
    end else if (r == 14) begin
      put_text("/*");
      k = $urandom_range(6);
      repeat (k) put_byte(8'(($urandom_range(2) == 0) ? 32'h2A : $urandom_range(1, 255)));
      if ($urandom_range(6) != 0) put_text("*/");
    end else if (r == 15) begin
      put_byte($urandom_range(1) ? 8'($urandom_range(128, 255)) : pick(ODD_CHARS));
    end else begin
      // raw noise
      put_byte(8'($urandom_range(1, 255)));
    end
  endtask

  // Close a source one of four ways: flag on the last byte, flag on an
  // extra byte, a zero byte, or a zero byte that also carries the flag.
  task automatic put_source_end();
    int       r;
    in_item_t it;
    r = $urandom_range(19);
    if (r < 9 && source_q.size() > 0) begin
      it = source_q.pop_back();
      it.end_of_source = 1'b1;
      source_q.push_back(it);
    end else if (r < 14) begin
      put_byte(8'($urandom_range(1, 255)), 1'b1);
    end else if (r < 19) begin
      put_byte(8'h00);
    end else begin
      put_byte(8'h00, 1'b1);
    end
  endtask

  task automatic put_random(int n);
    int goal;
    int k;
    goal = pushed_bytes + n;
    while (pushed_bytes < goal) begin
      k = $urandom_range(1, 12);
      repeat (k) begin
        put_random_token();
        if ($urandom_range(1)) put_byte(blank_byte());
      end
      put_source_end();
    end
  endtask

  // Short hand-picked sources: every token kind, a '-' and '/' that fall
  // back to operators, fraction with no digits, empty string, escape and
  // trailing backslash at end, both comment styles, a high byte, a byte
  // with two results, and an open comment killed by a zero byte.
  task automatic put_directed();
    put_text("k-2=-1.");
    put_byte(",", 1'b1);
    put_text("\"\"\"a");
    put_byte("\\", 1'b1);
    put_text("/x/**/-(");
    put_byte(8'hFF);
    put_text("#\t\n//");
    put_byte(8'h00);
  endtask

  // Identifier and string longer than the length clip.
  task automatic put_long_text();
    put_byte("q");
    repeat (515) put_byte(pick(IDENT_CHARS));
    put_byte(8'h00);
    put_byte("\"");
    repeat (515) put_byte(plain_str_byte());
    put_byte("\"", 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers the next byte at the falling edge, holds it until taken.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (source_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        in_data  <= source_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random gaps, occasional short holds, and the long hold
  // requested by the stimulus thread to fill the block's result queue.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if ($urandom_range(499) == 0) begin
      hold_left <= $urandom_range(20, 60);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on every accepted byte, checks every accepted token,
  // and runs the watchdog.
  // --------------------------------------------------------------------------
  function automatic string fmt_token(out_item_t t);
    return $sformatf("kind %0d start %0d len %0d first %02h index %0d last %0b",
                     t.token_kind, t.start_offset, t.text_length, t.first_byte,
                     t.token_index, t.last_of_run);
  endfunction

  task automatic flag_error(string msg);
    if (bad_count < MAX_REPORTS) $display("%0t ERROR %s", $realtime, msg);
    bad_count++;
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      in_took      <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) predict_tokens(in_data);
      if (out_valid && out_ready) begin
        if (token_q.size() == 0) begin
          flag_error({"token with none expected: ", fmt_token(out_data)});
        end else begin
          want = token_q.pop_front();
          if (out_data.token_kind   !== want.token_kind   ||
              out_data.start_offset !== want.start_offset ||
              out_data.text_length  !== want.text_length  ||
              out_data.first_byte   !== want.first_byte   ||
              out_data.token_index  !== want.token_index  ||
              out_data.last_of_run  !== want.last_of_run)
            flag_error({"token mismatch: got ", fmt_token(out_data),
                        " / expected ", fmt_token(want)});
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t watchdog: no traffic for %0d cycles", $realtime, QUIET_LIMIT);
        $display("config_language_tokenizer test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  task automatic drain();
    while (source_q.size() != 0 || in_valid || token_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    clear_lexer();

    // phase 1: sender gaps light, receiver gaps heavy
    send_gap_pct = 20;
    recv_gap_pct = 45;
    put_directed();
    put_random(250);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    drain();

    // phase 2: the other way round
    send_gap_pct = 45;
    recv_gap_pct = 20;
    put_random(250);
    drain();

    // phase 3: no random gaps; the long receiver hold lands on a steady
    // byte stream so the result queue fills and in_ready drops
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_req = hold_req + 1;
    put_random(150);
    put_long_text();
    put_random(120);
    drain();

    // let any stray token show up before the verdict
    repeat (10) @(posedge clk);
    if (bad_count == 0 && token_q.size() == 0) begin
      $display("config_language_tokenizer test passed");
    end else begin
      $display("config_language_tokenizer test failed");
    end
    $finish;
  end

endmodule
